@@ rtl/core/pptlb_pkg.sv @@
// Package for the paired page TLB: payload structs, action codes, status codes.
// No dependencies.
package pptlb_pkg;

	localparam logic [2:0] ACT_TRANSLATE = 3'd0;
	localparam logic [2:0] ACT_READ      = 3'd1;
	localparam logic [2:0] ACT_WRITE_IDX = 3'd2;
	localparam logic [2:0] ACT_WRITE_RND = 3'd3;
	localparam logic [2:0] ACT_PROBE     = 3'd4;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_MISS    = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;

	localparam logic [63:0] FLAT_MASK = 64'h1FFF_FFFF;

	typedef struct packed {
		logic [2:0]  action;
		logic [63:0] vaddr;
		logic        is_write;
		logic [63:0] entry_hi;
		logic [63:0] entry_lo0;
		logic [63:0] entry_lo1;
		logic [31:0] page_mask;
		logic [5:0]  index;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] phys_addr;
		logic        probe_hit;
		logic [5:0]  probe_index;
		logic [63:0] read_hi;
		logic [51:0] read_lo0;
		logic [51:0] read_lo1;
		logic [31:0] read_page_mask;
		logic        read_mask_valid;
	} rsp_t;

	// controller -> datapath commands
	typedef struct packed {
		logic load;     // capture request
		logic exec;     // evaluate and write state
	} cmd_t;

endpackage

@@ rtl/core/pptlb_ctrl.sv @@
// Controller for the paired page TLB: two-state sequencer, capture then execute.
// Depends on pptlb_pkg.
module pptlb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output pptlb_pkg::cmd_t   cmd
);
	import pptlb_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (start) state_q <= S_EXEC;
				S_EXEC: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy     = (state_q == S_EXEC);
	assign cmd.load = start && (state_q == S_IDLE);
	assign cmd.exec = (state_q == S_EXEC);
endmodule

@@ rtl/core/pptlb_dp.sv @@
// Datapath for the paired page TLB: entry registers, parallel compare, result register.
// Depends on pptlb_pkg.
module pptlb_dp #(
	parameter int ENTRY_COUNT = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pptlb_pkg::cmd_t   cmd,
	input  pptlb_pkg::req_t   req,
	input  logic              xlate_en,
	output pptlb_pkg::rsp_t   rsp,
	output logic              rsp_strobe
);
	import pptlb_pkg::*;

	localparam int IW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

	logic [ENTRY_COUNT-1:0] present_q;
	logic [51:0] vpn_q   [ENTRY_COUNT];
	logic [7:0]  asid_q  [ENTRY_COUNT];
	logic [51:0] fev_q   [ENTRY_COUNT];
	logic [51:0] fod_q   [ENTRY_COUNT];
	logic [5:0]  flg_q   [ENTRY_COUNT];
	logic [31:0] msk_q   [ENTRY_COUNT];
	logic [IW-1:0] rot_q;

	req_t r_q;
	rsp_t rsp_q;
	logic strobe_q;

	// index modulo entry count, from a constant table
	logic [IW-1:0] mod_tbl [64];
	for (genvar g = 0; g < 64; g++) begin : g_mod
		assign mod_tbl[g] = IW'(g % ENTRY_COUNT);
	end

	logic [IW-1:0] req_idx;
	assign req_idx = mod_tbl[req.index];

	logic [IW-1:0] rot_next;
	assign rot_next = (32'(rot_q) == ENTRY_COUNT - 1) ? '0 : rot_q + IW'(1);

	// compare runs on the incoming beat: translate keys on vaddr, probe on entry_hi
	logic [51:0] key;
	assign key = (req.action == ACT_PROBE) ? req.entry_hi[63:12] : req.vaddr[63:12];

	logic [ENTRY_COUNT-1:0] match;
	always_comb begin
		for (int i = 0; i < ENTRY_COUNT; i++) begin
			match[i] = present_q[i] && (vpn_q[i] == key) &&
				((asid_q[i] == req.entry_hi[7:0]) || flg_q[i][0] || flg_q[i][3]);
		end
	end

	logic          hit;
	logic [IW-1:0] hit_idx;
	always_comb begin
		hit = 1'b0;
		hit_idx = '0;
		for (int i = ENTRY_COUNT - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit = 1'b1;
				hit_idx = IW'(i);
			end
		end
	end

	// one entry read per beat: the read slot, or the lowest matching slot
	logic [IW-1:0] raddr;
	assign raddr = (req.action == ACT_READ) ? req_idx : hit_idx;

	logic          hit_s1;
	logic [IW-1:0] hit_idx_s1;
	logic [IW-1:0] idx_s1;
	logic          prs_s1;
	logic [51:0]   vpn_s1;
	logic [7:0]    asid_s1;
	logic [51:0]   fev_s1;
	logic [51:0]   fod_s1;
	logic [5:0]    flg_s1;
	logic [31:0]   msk_s1;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			r_q        <= req;
			hit_s1     <= hit;
			hit_idx_s1 <= hit_idx;
			idx_s1     <= req_idx;
			prs_s1     <= present_q[raddr];
			vpn_s1     <= vpn_q[raddr];
			asid_s1    <= asid_q[raddr];
			fev_s1     <= fev_q[raddr];
			fod_s1     <= fod_q[raddr];
			flg_s1     <= flg_q[raddr];
			msk_s1     <= msk_q[raddr];
		end
	end

	logic odd;
	logic [2:0]  f;
	logic [51:0] frame;
	assign odd   = r_q.vaddr[12];
	assign f     = odd ? flg_s1[5:3] : flg_s1[2:0];
	assign frame = odd ? fod_s1 : fev_s1;

	rsp_t res;
	always_comb begin
		res = '0;
		case (r_q.action)
			ACT_TRANSLATE: begin
				if (!xlate_en) begin
					res.phys_addr = r_q.vaddr & FLAT_MASK;
				end else if (!hit_s1) begin
					res.status = ST_MISS;
				end else if (!f[1] || (r_q.is_write && !f[2])) begin
					res.status = ST_INVALID;
				end else begin
					res.phys_addr = {frame, 12'd0} | {52'd0, r_q.vaddr[11:0]};
				end
			end
			ACT_READ: begin
				if (prs_s1) begin
					res.read_hi = {vpn_s1, 4'd0, asid_s1};
					res.read_lo0 = fev_s1;
					res.read_lo1 = fod_s1;
					res.read_page_mask = msk_s1;
					res.read_mask_valid = 1'b1;
				end
			end
			ACT_PROBE: begin
				if (hit_s1) begin
					res.probe_hit = 1'b1;
					res.probe_index = 6'(hit_idx_s1);
				end
			end
			default: ;
		endcase
	end

	logic          wr;
	logic [IW-1:0] wslot;
	assign wr    = cmd.exec && (r_q.action == ACT_WRITE_IDX || r_q.action == ACT_WRITE_RND);
	assign wslot = (r_q.action == ACT_WRITE_RND) ? rot_next : idx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			rot_q <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.exec;
			if (wr) present_q[wslot] <= 1'b1;
			if (cmd.exec && r_q.action == ACT_WRITE_RND) rot_q <= rot_next;
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			vpn_q[wslot]  <= r_q.entry_hi[63:12];
			asid_q[wslot] <= r_q.entry_hi[7:0];
			fev_q[wslot]  <= r_q.entry_lo0[51:0];
			fod_q[wslot]  <= r_q.entry_lo1[51:0];
			flg_q[wslot]  <= {r_q.entry_lo1[2:0], r_q.entry_lo0[2:0]};
			msk_q[wslot]  <= r_q.page_mask;
		end
		if (cmd.exec) rsp_q <= res;
	end

	assign rsp = rsp_q;
	assign rsp_strobe = strobe_q;
endmodule

@@ rtl/core/paired_page_tlb_unit.sv @@
// Paired page TLB top level: controller plus datapath, one item in flight.
// Done strobes once the result register is written; start is ignored while busy. The tag compare
// runs on the incoming beat and registers one entry read; busy for one cycle while the
// result is formed from that read and any entry write lands.
// Reset clears all present bits, the rotating slot and translate_enable.
// Results are shown for one cycle on done; the receiver cannot stall.
// Depends on pptlb_pkg, pptlb_ctrl, pptlb_dp.
module paired_page_tlb_unit #(
	parameter int ENTRY_COUNT = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  pptlb_pkg::req_t   req,
	output logic              done,
	output pptlb_pkg::rsp_t   rsp,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_data
);
	import pptlb_pkg::*;

	cmd_t cmd;
	logic en_q;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) en_q <= 1'b0;
		else if (cfg_valid) en_q <= cfg_data;
	end

	pptlb_ctrl u_ctrl (.clk, .arst_n, .start, .busy, .cmd);

	pptlb_dp #(.ENTRY_COUNT(ENTRY_COUNT)) u_dp (
		.clk, .arst_n, .cmd, .req, .xlate_en(en_q), .rsp, .rsp_strobe(done)
	);
endmodule
